// ----- rtl/aclc_pkg.sv -----
package aclc_pkg;

	// geometry of the cache
	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;

	// fixed field widths
	localparam int CAP_W       = 5;
	localparam int STATUS_W    = 3;
	localparam int OUT_VALUE_W = 32;

	// derived widths
	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int RANK_W = IDX_W;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// operation codes
	localparam logic FN_FIND   = 1'b0;
	localparam logic FN_INSERT = 1'b1;

	// result codes
	typedef enum logic [STATUS_W-1:0] {
		ST_HIT     = 3'd0,
		ST_MISS    = 3'd1,
		ST_FREE    = 3'd2,
		ST_REPLACE = 3'd3,
		ST_REFUSED = 3'd4
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE
	} fsm_t;

	// one word of the key/value memory
	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} kv_entry_t;

	// recency update request
	typedef struct packed {
		logic              en;
		logic              age_all;
		logic              set_valid;
		logic [RANK_W-1:0] limit;
		logic [IDX_W-1:0]  idx;
	} rank_cmd_t;

	// recency table lookups
	typedef struct packed {
		logic [ENTRIES-1:0] valid;
		logic               free_found;
		logic [IDX_W-1:0]   free_idx;
		logic               victim_found;
		logic [IDX_W-1:0]   victim_idx;
		logic [RANK_W-1:0]  hit_rank;
	} rank_info_t;

endpackage

// ----- rtl/aclc_if.sv -----
// request channel: operation, key and value
interface aclc_req_if;
	logic                            valid;
	logic                            ready;
	logic                            func;
	logic [aclc_pkg::KEY_BITS-1:0]   key;
	logic [aclc_pkg::VALUE_BITS-1:0] value;

	modport source(output valid, func, key, value, input ready);
	modport sink(input valid, func, key, value, output ready);
endinterface

// response channel: status and found value
interface aclc_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [aclc_pkg::STATUS_W-1:0]    status;
	logic [aclc_pkg::OUT_VALUE_W-1:0] value_out;

	modport source(output valid, status, value_out, input ready);
	modport sink(input valid, status, value_out, output ready);
endinterface

// capacity register write channel
interface aclc_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [aclc_pkg::CAP_W-1:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// ----- rtl/age_counter_lru_cache_unit.sv -----
// Fully associative key/value cache with least-recently-used replacement.
// req carries func (find or insert), key and value; rsp returns status and
// value_out, one response word per request word, in order. cfg writes the
// capacity register (reset value 16, values above the entry count act as
// the entry count); write it only while no request is in flight.
// A request is taken only while the unit is idle. Keys and values live in
// a single-port-read memory with a registered read; the unit sweeps all
// entries one per cycle and takes no new request until its update step is
// done. Recency ranks and valid bits sit in a small register table that
// is aged in a single step.
// The response sits in an output register: a stalled receiver does not
// block the next request, but a finished request waits in its update step
// until the previous response has been taken.
// Reset clears the valid bits, the fill count and the response valid flag
// and loads the capacity with 16; the memory contents are not cleared and
// need no clearing pass.
module age_counter_lru_cache_unit (
	input logic       clk,
	input logic       arst_n,
	aclc_req_if.sink  req,
	aclc_rsp_if.source rsp,
	aclc_cfg_if.sink  cfg
);

	aclc_pkg::fsm_t state_q, state_d;

	logic [aclc_pkg::IDX_W:0]        cnt_q;
	logic                            func_q;
	logic [aclc_pkg::KEY_BITS-1:0]   key_q;
	logic [aclc_pkg::VALUE_BITS-1:0] value_q;
	logic [aclc_pkg::CAP_W-1:0]      capacity_q;
	logic [aclc_pkg::CNT_W-1:0]      fill_q;

	logic                            hit_q;
	logic [aclc_pkg::IDX_W-1:0]      hit_idx_q;
	logic [aclc_pkg::VALUE_BITS-1:0] hit_val_q;

	logic                            vld_s1;
	logic [aclc_pkg::IDX_W-1:0]      idx_s1;
	aclc_pkg::kv_entry_t             rd_data_s1;

	logic                             out_valid_q;
	logic [aclc_pkg::STATUS_W-1:0]    status_q;
	logic [aclc_pkg::OUT_VALUE_W-1:0] value_out_q;

	aclc_pkg::kv_entry_t kv_mem [aclc_pkg::ENTRIES];

	logic                        accept;
	logic                        rd_en;
	logic [aclc_pkg::IDX_W-1:0]  rd_addr;
	logic                        match;
	logic                        last_cmp;
	logic                        out_free;
	logic                        fire;

	logic                        mem_we;
	logic [aclc_pkg::IDX_W-1:0]  mem_waddr;
	logic                        fill_inc;
	aclc_pkg::status_t           status_d;
	logic [aclc_pkg::OUT_VALUE_W-1:0] value_d;
	aclc_pkg::rank_cmd_t         rank_cmd;
	aclc_pkg::rank_info_t        info;

	logic [aclc_pkg::CMP_W-1:0]  cap_ext;
	logic [aclc_pkg::CMP_W-1:0]  cap_eff;
	logic [aclc_pkg::CMP_W-1:0]  fill_ext;
	logic [aclc_pkg::RANK_W-1:0] oldest;

	// handshakes
	assign req.ready = (state_q == aclc_pkg::S_IDLE);
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = status_q;
	assign rsp.value_out = value_out_q;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= aclc_pkg::CAP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			capacity_q <= cfg.data;
		end
	end

	// sweep address, one entry per cycle
	assign rd_en   = (state_q == aclc_pkg::S_SCAN) &&
	                 (cnt_q < (aclc_pkg::IDX_W + 1)'(aclc_pkg::ENTRIES));
	assign rd_addr = cnt_q[aclc_pkg::IDX_W-1:0];

	// key/value memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			kv_mem[mem_waddr] <= '{key: key_q, value: value_q};
		end
		if (rd_en) begin
			rd_data_s1 <= kv_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
	end

	// compare stage
	assign match    = vld_s1 && info.valid[idx_s1] && (rd_data_s1.key == key_q);
	assign last_cmp = vld_s1 && (idx_s1 == aclc_pkg::IDX_W'(aclc_pkg::ENTRIES - 1));

	// request capture and hit tracking
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= req.func;
			key_q   <= req.key;
			value_q <= req.value;
		end
		if (match && !hit_q) begin
			hit_idx_q <= idx_s1;
			hit_val_q <= rd_data_s1.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aclc_pkg::S_IDLE;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			hit_q       <= 1'b0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;
			if (accept) begin
				cnt_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (rd_en) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
			if (fill_inc) begin
				fill_q <= fill_q + 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q    <= status_d;
			value_out_q <= value_d;
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			aclc_pkg::S_IDLE: begin
				if (accept) begin
					state_d = aclc_pkg::S_SCAN;
				end
			end
			aclc_pkg::S_SCAN: begin
				if (last_cmp) begin
					state_d = aclc_pkg::S_UPDATE;
				end
			end
			aclc_pkg::S_UPDATE: begin
				if (out_free) begin
					state_d = aclc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = aclc_pkg::S_IDLE;
			end
		endcase
	end

	assign out_free = !out_valid_q || rsp.ready;
	assign fire     = (state_q == aclc_pkg::S_UPDATE) && out_free;

	// effective capacity and the rank of the oldest entry
	assign cap_ext  = aclc_pkg::CMP_W'(capacity_q);
	assign cap_eff  = (cap_ext > aclc_pkg::CMP_W'(aclc_pkg::ENTRIES)) ?
	                  aclc_pkg::CMP_W'(aclc_pkg::ENTRIES) : cap_ext;
	assign fill_ext = aclc_pkg::CMP_W'(fill_q);
	assign oldest   = aclc_pkg::RANK_W'(fill_q - 1'b1);

	// decision for the finished sweep
	always_comb begin
		status_d          = aclc_pkg::ST_REFUSED;
		value_d           = '0;
		rank_cmd          = '0;
		mem_we            = 1'b0;
		mem_waddr         = info.free_idx;
		fill_inc          = 1'b0;
		if (func_q == aclc_pkg::FN_FIND) begin
			if (hit_q) begin
				status_d       = aclc_pkg::ST_HIT;
				value_d        = aclc_pkg::OUT_VALUE_W'(hit_val_q);
				rank_cmd.en    = fire;
				rank_cmd.limit = info.hit_rank;
				rank_cmd.idx   = hit_idx_q;
			end else begin
				status_d = aclc_pkg::ST_MISS;
			end
		end else if (hit_q || cap_eff == '0) begin
			status_d = aclc_pkg::ST_REFUSED;
		end else if (fill_ext < cap_eff) begin
			if (info.free_found) begin
				status_d           = aclc_pkg::ST_FREE;
				rank_cmd.en        = fire;
				rank_cmd.age_all   = 1'b1;
				rank_cmd.set_valid = 1'b1;
				rank_cmd.idx       = info.free_idx;
				mem_we             = fire;
				mem_waddr          = info.free_idx;
				fill_inc           = fire;
			end
		end else if (info.victim_found) begin
			status_d       = aclc_pkg::ST_REPLACE;
			rank_cmd.en    = fire;
			rank_cmd.limit = oldest;
			rank_cmd.idx   = info.victim_idx;
			mem_we         = fire;
			mem_waddr      = info.victim_idx;
		end
	end

	aclc_rank_table u_rank (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (rank_cmd),
		.hit_idx (hit_idx_q),
		.oldest  (oldest),
		.info    (info)
	);

	// fill count tracks the number of valid entries
	a_fill_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(info.valid) == int'(fill_q))
		else $error("fill count differs from number of valid entries");

	// memory is never written during the sweep
	a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == aclc_pkg::S_UPDATE) && !rd_en)
		else $error("memory write overlaps the sweep");

	// an accepted word starts a fresh sweep
	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == aclc_pkg::S_SCAN) && !hit_q && cnt_q == '0)
		else $error("sweep did not restart on accept");

	// a finished update always leaves a response in the output register
	a_fire_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q && (state_q == aclc_pkg::S_IDLE))
		else $error("update did not produce a response");

	// no insert beyond the entry count
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_inc |-> fill_q < aclc_pkg::CNT_W'(aclc_pkg::ENTRIES))
		else $error("fill count overflow");

endmodule

// ----- rtl/aclc_rank_table.sv -----
module aclc_rank_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  aclc_pkg::rank_cmd_t               cmd,
	input  logic [aclc_pkg::IDX_W-1:0]        hit_idx,
	input  logic [aclc_pkg::RANK_W-1:0]       oldest,
	output aclc_pkg::rank_info_t              info
);

	logic [aclc_pkg::ENTRIES-1:0] valid_q;
	logic [aclc_pkg::RANK_W-1:0]  rank_q [aclc_pkg::ENTRIES];

	// valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.en && cmd.set_valid) begin
			valid_q[cmd.idx] <= 1'b1;
		end
	end

	// aging: entries younger than the limit (or all valid entries) step back, selected entry becomes most recent
	always_ff @(posedge clk) begin
		if (cmd.en) begin
			for (int i = 0; i < aclc_pkg::ENTRIES; i++) begin
				if (valid_q[i] && (cmd.age_all || rank_q[i] < cmd.limit)) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
			rank_q[cmd.idx] <= '0;
		end
	end

	// lowest free slot and the oldest valid entry
	always_comb begin
		info              = '0;
		info.valid        = valid_q;
		info.hit_rank     = rank_q[hit_idx];
		for (int i = aclc_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				info.free_found = 1'b1;
				info.free_idx   = aclc_pkg::IDX_W'(i);
			end
			if (valid_q[i] && rank_q[i] == oldest) begin
				info.victim_found = 1'b1;
				info.victim_idx   = aclc_pkg::IDX_W'(i);
			end
		end
	end

endmodule

// ----- bench/age_counter_lru_cache_unit_test.sv -----
`timescale 1ns / 100ps

module age_counter_lru_cache_unit_test;

	localparam int POOL       = 24;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 100;

	typedef struct {
		logic                            func;
		logic [aclc_pkg::KEY_BITS-1:0]   key;
		logic [aclc_pkg::VALUE_BITS-1:0] value;
	} access_t;

	typedef struct {
		aclc_pkg::status_t                status;
		logic [aclc_pkg::OUT_VALUE_W-1:0] value;
	} rsp_word_t;

	logic clk;
	logic arst_n;

	aclc_req_if req_ch();
	aclc_rsp_if rsp_ch();
	aclc_cfg_if cfg_ch();

	age_counter_lru_cache_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// shadow copy of the cache contents
	logic                            held[aclc_pkg::ENTRIES];
	logic [aclc_pkg::KEY_BITS-1:0]   held_key[aclc_pkg::ENTRIES];
	logic [aclc_pkg::VALUE_BITS-1:0] held_value[aclc_pkg::ENTRIES];
	int                              held_rank[aclc_pkg::ENTRIES];
	int                              fill_model;
	int                              cap_model;

	access_t                       access_queue[$];
	rsp_word_t                     due_responses[$];
	logic [aclc_pkg::KEY_BITS-1:0] key_pool[POOL];

	int   sent_count = 0;
	int   resp_count = 0;
	int   errors     = 0;
	int   cycles     = 0;
	int   req_gap;
	int   rsp_gap;
	logic req_took;
	logic quiet_tail;

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// every held entry younger than limit moves one step older
	function automatic void age_below(input int limit);
		for (int i = 0; i < aclc_pkg::ENTRIES; i++)
			if (held[i] && held_rank[i] < limit)
				held_rank[i]++;
	endfunction

	// expected response of one find or insert, updating the shadow cache
	function automatic rsp_word_t predict_access(input access_t a);
		rsp_word_t r;
		int hit, slot, victim, oldest, eff;
		hit = -1;
		slot = -1;
		victim = -1;
		oldest = 0;
		eff = (cap_model > aclc_pkg::ENTRIES) ? aclc_pkg::ENTRIES : cap_model;
		r.status = aclc_pkg::ST_MISS;
		r.value = '0;
		for (int i = 0; i < aclc_pkg::ENTRIES; i++)
			if (hit < 0 && held[i] && held_key[i] == a.key)
				hit = i;
		if (a.func == aclc_pkg::FN_FIND) begin
			if (hit >= 0) begin
				age_below(held_rank[hit]);
				held_rank[hit] = 0;
				r.status = aclc_pkg::ST_HIT;
				r.value = held_value[hit];
			end
		end else if (hit >= 0 || eff == 0) begin
			r.status = aclc_pkg::ST_REFUSED;
		end else if (fill_model < eff) begin
			for (int i = 0; i < aclc_pkg::ENTRIES; i++)
				if (slot < 0 && !held[i])
					slot = i;
			if (slot < 0) begin
				r.status = aclc_pkg::ST_REFUSED;
			end else begin
				age_below(aclc_pkg::ENTRIES);
				held[slot] = 1'b1;
				held_key[slot] = a.key;
				held_value[slot] = a.value;
				held_rank[slot] = 0;
				fill_model++;
				r.status = aclc_pkg::ST_FREE;
			end
		end else begin
			// cache counts as full: overwrite the least recent entry
			for (int i = 0; i < aclc_pkg::ENTRIES; i++)
				if (held[i] && (victim < 0 || held_rank[i] > oldest)) begin
					victim = i;
					oldest = held_rank[i];
				end
			if (victim < 0) begin
				r.status = aclc_pkg::ST_REFUSED;
			end else begin
				age_below(oldest);
				held_key[victim] = a.key;
				held_value[victim] = a.value;
				held_rank[victim] = 0;
				r.status = aclc_pkg::ST_REPLACE;
			end
		end
		return r;
	endfunction

	// request driver: holds a word until taken, idles in bursts
	always @(negedge clk) begin
		access_t nxt;
		if (!arst_n) begin
			req_gap <= 0;
			req_ch.valid <= 1'b0;
			req_ch.func <= aclc_pkg::FN_FIND;
			req_ch.key <= '0;
			req_ch.value <= '0;
		end else if (!(req_ch.valid && !req_took)) begin
			if (req_gap > 0) begin
				req_gap <= req_gap - 1;
				req_ch.valid <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				req_gap <= $urandom_range(0, 7);
				req_ch.valid <= 1'b0;
			end else if (access_queue.size() != 0) begin
				nxt = access_queue.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.func <= nxt.func;
				req_ch.key <= nxt.key;
				req_ch.value <= nxt.value;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// response receiver: stalls in bursts
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_gap <= 0;
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_gap > 0) begin
				rsp_gap <= rsp_gap - 1;
				rsp_ch.ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				rsp_gap <= $urandom_range(0, 7);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// monitor: check responses, predict accepted requests
	always @(posedge clk or negedge arst_n) begin
		access_t   a;
		rsp_word_t exp_word;
		if (!arst_n) begin
			req_took <= 1'b0;
			fill_model = 0;
			for (int i = 0; i < aclc_pkg::ENTRIES; i++) begin
				held[i] = 1'b0;
				held_key[i] = '0;
				held_value[i] = '0;
				held_rank[i] = 0;
			end
		end else begin
			req_took <= req_ch.valid && req_ch.ready;
			if (rsp_ch.valid && rsp_ch.ready) begin
				resp_count <= resp_count + 1;
				if (due_responses.size() == 0) begin
					$display("%0t: unexpected response word status %0d value_out %h",
						$time, rsp_ch.status, rsp_ch.value_out);
					errors++;
				end else begin
					exp_word = due_responses.pop_front();
					if (rsp_ch.status !== exp_word.status) begin
						$display("%0t: status expected %0d got %0d",
							$time, exp_word.status, rsp_ch.status);
						errors++;
					end
					if (rsp_ch.value_out !== exp_word.value) begin
						$display("%0t: value_out expected %h got %h",
							$time, exp_word.value, rsp_ch.value_out);
						errors++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				a.func = req_ch.func;
				a.key = req_ch.key;
				a.value = req_ch.value;
				due_responses.push_back(predict_access(a));
			end
		end
	end

	// run length guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL age_counter_lru_cache_unit");
			$finish;
		end
	end

	task automatic queue_access(input logic fn, input logic [aclc_pkg::KEY_BITS-1:0] k,
		input logic [aclc_pkg::VALUE_BITS-1:0] v);
		access_t a;
		a.func = fn;
		a.key = k;
		a.value = v;
		access_queue.push_back(a);
		sent_count++;
	endtask

	// wait until every queued word has been answered
	task automatic wait_drained();
		while (resp_count != sent_count)
			@(negedge clk);
	endtask

	// capacity write while the unit is idle
	task automatic write_capacity(input int v);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= aclc_pkg::CAP_W'(v);
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cap_model = v;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// random traffic over a key pool sized around the capacity
	task automatic random_phase(input int n);
		int span, eff;
		logic fn;
		logic [aclc_pkg::KEY_BITS-1:0] k;
		eff = (cap_model > aclc_pkg::ENTRIES) ? aclc_pkg::ENTRIES : cap_model;
		span = eff + $urandom_range(1, 8);
		if (span > POOL)
			span = POOL;
		for (int i = 0; i < n; i++) begin
			fn = ($urandom_range(0, 9) < 4) ? aclc_pkg::FN_INSERT : aclc_pkg::FN_FIND;
			if ($urandom_range(0, 9) == 0)
				k = $urandom;
			else
				k = key_pool[$urandom_range(0, span - 1)];
			queue_access(fn, k, $urandom);
		end
		wait_drained();
	endtask

	// stimulus
	initial begin
		int caps[11];
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		quiet_tail = 1'b0;
		cap_model = int'(aclc_pkg::CAP_RESET);
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL; i++)
			key_pool[i] = $urandom;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset capacity: empty miss, fills, hits, duplicate refusal
		queue_access(aclc_pkg::FN_FIND, '0, '0);
		queue_access(aclc_pkg::FN_INSERT, '0, '0);
		queue_access(aclc_pkg::FN_INSERT, '1, '1);
		queue_access(aclc_pkg::FN_FIND, '1, '0);
		queue_access(aclc_pkg::FN_FIND, '0, '1);
		queue_access(aclc_pkg::FN_INSERT, '0, 32'h0000_0005);
		queue_access(aclc_pkg::FN_FIND, 32'h1234_5678, '0);
		queue_access(aclc_pkg::FN_FIND, 32'h8765_4321, '1);
		wait_drained();

		// zero capacity refuses every insert, finds still hit
		write_capacity(0);
		queue_access(aclc_pkg::FN_INSERT, 32'haaaa_5555, 32'h5555_aaaa);
		queue_access(aclc_pkg::FN_FIND, '0, '0);
		wait_drained();

		// capacity below the fill count: inserts replace the oldest
		write_capacity(1);
		queue_access(aclc_pkg::FN_INSERT, 32'h0000_0001, 32'hdead_beef);
		queue_access(aclc_pkg::FN_FIND, '1, '0);
		queue_access(aclc_pkg::FN_FIND, 32'h0000_0001, '0);
		queue_access(aclc_pkg::FN_INSERT, 32'h0000_0002, 32'h0bad_f00d);
		wait_drained();

		// capacity above the entry count saturates
		write_capacity(31);
		queue_access(aclc_pkg::FN_INSERT, 32'h0000_0003, 32'h1111_1111);
		queue_access(aclc_pkg::FN_INSERT, 32'h0000_0004, 32'h2222_2222);
		queue_access(aclc_pkg::FN_FIND, 32'h0000_0001, '0);
		wait_drained();

		// random phases over several capacities
		caps = '{16, 4, 0, 31, 1, 9, 2, 17, 16, 0, 6};
		caps[9] = $urandom_range(0, 31);
		for (int p = 0; p < 11; p++) begin
			write_capacity(caps[p]);
			if (p == 10)
				quiet_tail = 1'b1;
			random_phase(PHASE_ITEMS);
		end

		repeat (40) @(posedge clk);
		if (errors == 0 && due_responses.size() == 0) begin
			$display("PASS age_counter_lru_cache_unit");
		end else begin
			$display("FAIL age_counter_lru_cache_unit");
		end
		$finish;
	end

endmodule
